// File: design/siht_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted interrupt handler table.
// No dependencies; used by every other file of the block.

package siht_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 10;
    localparam int TASK_W      = 32;
    localparam int LIMIT_W     = 11;
    localparam int STATUS_W    = 2;
    localparam int ENTRY_W     = KEY_W + TASK_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXISTS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic                load;
        logic                probe;
        logic                narrow;
        logic                shift_start;
        logic                shift_step;
        logic                place;
        logic                res_we;
        logic [STATUS_W-1:0] res_status;
        logic                res_found;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_lookup;
        logic span_open;
        logic key_eq;
        logic invalid;
        logic full;
        logic shift_busy;
    } dp_stat_t;

endpackage

// File: design/siht_in_if.sv
`timescale 1ns / 1ps
// Request channel interface: valid/ready plus one command word.
// Depends on siht_pkg.

interface siht_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [siht_pkg::KEY_W-1:0]  irq_number;
    logic [siht_pkg::TASK_W-1:0] owner_task;

    modport source (output valid, command, irq_number, owner_task, input ready);
    modport sink   (input valid, command, irq_number, owner_task, output ready);
endinterface

// File: design/siht_out_if.sv
`timescale 1ns / 1ps
// Response channel interface: valid/ready plus one result word.
// Depends on siht_pkg.

interface siht_out_if;
    logic                          valid;
    logic                          ready;
    logic [siht_pkg::STATUS_W-1:0] status;
    logic                          found;
    logic [siht_pkg::TASK_W-1:0]   found_task;
    logic                          enable_request;
    logic [siht_pkg::KEY_W-1:0]    enable_number;

    modport source (output valid, status, found, found_task, enable_request, enable_number,
                    input ready);
    modport sink   (input valid, status, found, found_task, enable_request, enable_number,
                    output ready);
endinterface

// File: design/siht_datapath.sv
`timescale 1ns / 1ps
// Datapath: entry memory, search bounds, shift pointer, count, limit and result word.
// Depends on siht_pkg; driven by siht_ctrl.

module siht_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            command,
    input  logic [siht_pkg::KEY_W-1:0]      irq_number,
    input  logic [siht_pkg::TASK_W-1:0]     owner_task,
    input  logic                            cfg_we,
    input  logic [siht_pkg::LIMIT_W-1:0]    cfg_wdata,
    input  siht_pkg::dp_cmd_t               cmd,
    output siht_pkg::dp_stat_t              stat,
    output logic [siht_pkg::STATUS_W-1:0]   status,
    output logic                            found,
    output logic [siht_pkg::TASK_W-1:0]     found_task,
    output logic                            enable_request,
    output logic [siht_pkg::KEY_W-1:0]      enable_number
);

    logic [siht_pkg::ENTRY_W-1:0] entry_mem [siht_pkg::TABLE_DEPTH];

    logic                          cmd_reg;
    logic [siht_pkg::KEY_W-1:0]    key_reg;
    logic [siht_pkg::TASK_W-1:0]   task_reg;
    logic [siht_pkg::CNT_W-1:0]    lo_reg;
    logic [siht_pkg::CNT_W-1:0]    hi_reg;
    logic [siht_pkg::IDX_W-1:0]    mid_reg;
    logic [siht_pkg::CNT_W-1:0]    ptr_reg;
    logic [siht_pkg::CNT_W-1:0]    count_reg;
    logic [siht_pkg::LIMIT_W-1:0]  limit_reg;
    logic                          shift_pend_reg;
    logic [siht_pkg::IDX_W-1:0]    shift_wr_addr_reg;
    logic [siht_pkg::ENTRY_W-1:0]  rd_data_reg;

    logic [siht_pkg::STATUS_W-1:0] status_reg;
    logic                          found_reg;
    logic [siht_pkg::TASK_W-1:0]   found_task_reg;
    logic                          enable_request_reg;
    logic [siht_pkg::KEY_W-1:0]    enable_number_reg;

    logic [siht_pkg::CNT_W:0]      bound_sum;
    logic [siht_pkg::IDX_W-1:0]    mid_next;
    logic [siht_pkg::CNT_W-1:0]    ptr_dec;
    logic [siht_pkg::IDX_W-1:0]    rd_addr;
    logic [siht_pkg::KEY_W-1:0]    rd_key;
    logic [siht_pkg::TASK_W-1:0]   rd_owner;
    logic                          wr_en;
    logic [siht_pkg::IDX_W-1:0]    wr_addr;
    logic [siht_pkg::ENTRY_W-1:0]  wr_data;

    assign bound_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_next  = bound_sum[siht_pkg::IDX_W:1];
    assign ptr_dec   = ptr_reg - 1'b1;
    assign rd_key    = rd_data_reg[siht_pkg::ENTRY_W-1:siht_pkg::TASK_W];
    assign rd_owner  = rd_data_reg[siht_pkg::TASK_W-1:0];

    // hold the probe address when idle so a stalled compare keeps its data
    always_comb
    begin
        if (cmd.probe)
        begin
            rd_addr = mid_next;
        end
        else if (cmd.shift_step)
        begin
            rd_addr = ptr_dec[siht_pkg::IDX_W-1:0];
        end
        else
        begin
            rd_addr = mid_reg;
        end
    end

    // shift write-back of last cycle's read, else placement of the new entry
    always_comb
    begin
        wr_en   = shift_pend_reg | cmd.place;
        wr_addr = shift_pend_reg ? shift_wr_addr_reg : lo_reg[siht_pkg::IDX_W-1:0];
        wr_data = shift_pend_reg ? rd_data_reg : {key_reg, task_reg};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            limit_reg      <= siht_pkg::LIMIT_RESET;
            shift_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.place)
            begin
                count_reg <= count_reg + 1'b1;
            end
            shift_pend_reg <= cmd.shift_step;
        end
    end

    // item, bounds and pointer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= command;
            key_reg  <= irq_number;
            task_reg <= owner_task;
            lo_reg   <= '0;
            hi_reg   <= count_reg;
        end
        if (cmd.probe)
        begin
            mid_reg <= mid_next;
        end
        if (cmd.narrow)
        begin
            if (rd_key < key_reg)
            begin
                lo_reg <= siht_pkg::CNT_W'(mid_reg) + 1'b1;
            end
            else
            begin
                hi_reg <= siht_pkg::CNT_W'(mid_reg);
            end
        end
        if (cmd.shift_start)
        begin
            ptr_reg <= count_reg;
        end
        if (cmd.shift_step)
        begin
            ptr_reg           <= ptr_dec;
            shift_wr_addr_reg <= ptr_reg[siht_pkg::IDX_W-1:0];
        end
        if (cmd.res_we)
        begin
            status_reg         <= cmd.res_status;
            found_reg          <= cmd.res_found;
            found_task_reg     <= cmd.res_found ? rd_owner : '0;
            enable_request_reg <= cmd.place;
            enable_number_reg  <= cmd.place ? key_reg : '0;
        end
    end

    always_comb
    begin
        stat.is_lookup  = (cmd_reg == siht_pkg::CMD_LOOKUP);
        stat.span_open  = (lo_reg < hi_reg);
        stat.key_eq     = (rd_key == key_reg);
        stat.invalid    = ({1'b0, key_reg} >= limit_reg);
        stat.full       = (count_reg >= siht_pkg::CNT_W'(siht_pkg::TABLE_DEPTH));
        stat.shift_busy = (ptr_reg > lo_reg);
    end

    assign status         = status_reg;
    assign found          = found_reg;
    assign found_task     = found_task_reg;
    assign enable_request = enable_request_reg;
    assign enable_number  = enable_number_reg;

endmodule

// File: design/siht_ctrl.sv
`timescale 1ns / 1ps
// Controller FSM: sequences search, shift and placement, owns the handshakes.
// Depends on siht_pkg; drives siht_datapath.

module siht_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  siht_pkg::dp_stat_t stat,
    output siht_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_WAIT,
        S_SHIFT,
        S_PLACE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (stat.span_open)
                begin
                    cmd.probe  = 1'b1;
                    state_next = S_WAIT;
                end
                else if (stat.is_lookup || stat.invalid || stat.full)
                begin
                    // miss: lookup reports ok, insert reports its rejection
                    if (out_free)
                    begin
                        cmd.res_we     = 1'b1;
                        cmd.res_status = stat.is_lookup ? siht_pkg::ST_OK :
                                         stat.invalid   ? siht_pkg::ST_INVALID :
                                                          siht_pkg::ST_FULL;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmd.shift_start = 1'b1;
                    state_next      = S_SHIFT;
                end
            end
            S_WAIT:
            begin
                if (stat.key_eq)
                begin
                    if (out_free)
                    begin
                        cmd.res_we     = 1'b1;
                        cmd.res_found  = stat.is_lookup;
                        cmd.res_status = stat.is_lookup ? siht_pkg::ST_OK : siht_pkg::ST_EXISTS;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmd.narrow = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SHIFT:
            begin
                if (stat.shift_busy)
                begin
                    cmd.shift_step = 1'b1;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                if (out_free)
                begin
                    cmd.place      = 1'b1;
                    cmd.res_we     = 1'b1;
                    cmd.res_status = siht_pkg::ST_OK;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: design/sorted_interrupt_handler_table_top.sv
`timescale 1ns / 1ps
// Top level of the sorted interrupt handler table.
// Depends on siht_pkg, siht_in_if, siht_out_if, siht_ctrl, siht_datapath.
//
//  channel | dir | handshake         | word
//  --------+-----+-------------------+-----------------------------------------------
//  req     | in  | valid/ready       | command, irq_number, owner_task
//  rsp     | out | valid/ready       | status, found, found_task, enable_request/number
//  cfg     | in  | cfg_we, no ready  | cfg_wdata -> interrupt_limit
//
// One word at a time: a load step, binary-search probes of a read and a compare each,
// at most 7 probes, and a decision step; an insert then moves one entry per cycle
// (at most 63), then ends the walk and places the new entry.
// A new request word is taken while the previous response still waits; the FSM
// stalls its final step until rsp.ready frees the response register.
// Reset empties the table (count to zero), sets the limit to 1024; memory is not cleared.

module sorted_interrupt_handler_table_top (
    input  logic                         clk,
    input  logic                         rst_n,
    siht_in_if.sink                      req,
    siht_out_if.source                   rsp,
    input  logic                         cfg_we,
    input  logic [siht_pkg::LIMIT_W-1:0] cfg_wdata
);

    siht_pkg::dp_cmd_t  cmd;
    siht_pkg::dp_stat_t stat;

    // sequencing and handshakes
    siht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // table storage, search bounds and result word
    siht_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .command        (req.command),
        .irq_number     (req.irq_number),
        .owner_task     (req.owner_task),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .cmd            (cmd),
        .stat           (stat),
        .status         (rsp.status),
        .found          (rsp.found),
        .found_task     (rsp.found_task),
        .enable_request (rsp.enable_request),
        .enable_number  (rsp.enable_number)
    );

endmodule

// File: design/siht_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the sorted interrupt handler table, with its bind.
// Depends on siht_pkg and sorted_interrupt_handler_table_top.

module siht_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [siht_pkg::STATUS_W-1:0] status,
    input logic                          found,
    input logic [siht_pkg::TASK_W-1:0]   found_task,
    input logic                          enable_request,
    input logic [siht_pkg::KEY_W-1:0]    enable_number
);

    // a stalled response stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("response dropped while stalled");

    // enable request only comes with a successful insert
    a_enable_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && enable_request |-> status == siht_pkg::ST_OK && !found)
        else $error("enable request on a failed or lookup word");

    // a lookup hit never carries an enable request
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == siht_pkg::ST_OK && !enable_request)
        else $error("lookup hit with bad status or enable");

    // responses without a hit or an enable request carry zero task and zero enable number
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found && !enable_request |-> found_task == '0 && enable_number == '0)
        else $error("nonzero payload on a plain response");

endmodule

bind sorted_interrupt_handler_table_top siht_checker u_siht_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .status         (rsp.status),
    .found          (rsp.found),
    .found_task     (rsp.found_task),
    .enable_request (rsp.enable_request),
    .enable_number  (rsp.enable_number)
);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted interrupt handler table.
// Depends on siht_pkg, siht_in_if, siht_out_if and sorted_interrupt_handler_table_top.

module testbench;

    // Run guard: the slowest legal run stays well below this many cycles.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Drain time at the end: one worst-case insert plus margin.
    localparam int TAIL_CYCLES = 120;

    // One request word and one response word, in the block's field widths.
    typedef struct packed {
        logic                        command;
        logic [siht_pkg::KEY_W-1:0]  irq_number;
        logic [siht_pkg::TASK_W-1:0] owner_task;
    } request_t;

    typedef struct packed {
        logic [siht_pkg::STATUS_W-1:0] status;
        logic                          found;
        logic [siht_pkg::TASK_W-1:0]   found_task;
        logic                          enable_request;
        logic [siht_pkg::KEY_W-1:0]    enable_number;
    } reply_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [siht_pkg::LIMIT_W-1:0]   cfg_wdata;

    siht_in_if  req_ch();
    siht_out_if rsp_ch();

    sorted_interrupt_handler_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the handler table and of the limit register.
    logic [siht_pkg::KEY_W-1:0]   tbl_key   [siht_pkg::TABLE_DEPTH];
    logic [siht_pkg::TASK_W-1:0]  tbl_owner [siht_pkg::TABLE_DEPTH];
    int                           tbl_count = 0;
    logic [siht_pkg::LIMIT_W-1:0] irq_limit = siht_pkg::LIMIT_RESET;

    request_t request_words[$];     // words waiting to be driven
    reply_t   expected_replies[$];  // predicted responses, oldest first
    int       key_pool[$];          // keys of directed and fresh inserts, for hits and duplicates

    int words_queued   = 0;
    int words_accepted = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    // Idle/stall odds in percent, changed between phases only.
    int req_idle_pct  = 0;
    int rsp_stall_pct = 0;

    // Coverage tallies for the closing summary.
    int n_placed = 0, n_exists = 0, n_invalid = 0, n_full = 0;
    int n_hit = 0, n_miss = 0;

    // 100 MHz clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d responses still pending", $time,
                     expected_replies.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Applies one word to the shadow table and returns the response it must give.
    // Keys in the table are unique and sorted, so a linear scan finds the same
    // entry the block's binary search does.
    function automatic reply_t apply_to_table(request_t w);
        reply_t r;
        int     slot;
        int     pos;
        r    = '0;
        slot = -1;
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_key[i] == w.irq_number)
                slot = i;
        end
        if (w.command == siht_pkg::CMD_LOOKUP)
        begin
            // lookup: status stays ok whether or not the key is present
            r.status = siht_pkg::ST_OK;
            if (slot >= 0)
            begin
                r.found      = 1'b1;
                r.found_task = tbl_owner[slot];
            end
        end
        else if (slot >= 0)
            r.status = siht_pkg::ST_EXISTS;  // duplicate wins over range and full checks
        else if ({1'b0, w.irq_number} >= irq_limit)
            r.status = siht_pkg::ST_INVALID;
        else if (tbl_count >= siht_pkg::TABLE_DEPTH)
            r.status = siht_pkg::ST_FULL;
        else
        begin
            // open a hole by moving larger keys up one slot
            pos = tbl_count;
            while (pos > 0 && tbl_key[pos-1] > w.irq_number)
            begin
                tbl_key[pos]   = tbl_key[pos-1];
                tbl_owner[pos] = tbl_owner[pos-1];
                pos--;
            end
            tbl_key[pos]     = w.irq_number;
            tbl_owner[pos]   = w.owner_task;
            tbl_count++;
            r.status         = siht_pkg::ST_OK;
            r.enable_request = 1'b1;
            r.enable_number  = w.irq_number;
        end
        return r;
    endfunction

    // Request driver: holds a word until it is taken, then maybe idles.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        request_t sent;
        request_t nxt;
        reply_t   want;
        logic     hold;
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.command    <= siht_pkg::CMD_INSERT;
            req_ch.irq_number <= '0;
            req_ch.owner_task <= '0;
        end
        else
        begin
            hold = req_ch.valid && !req_ch.ready;
            if (req_ch.valid && req_ch.ready)
            begin
                sent = '{req_ch.command, req_ch.irq_number, req_ch.owner_task};
                want = apply_to_table(sent);
                expected_replies = {expected_replies, want};
                words_accepted++;
                if (sent.command == siht_pkg::CMD_LOOKUP)
                begin
                    if (want.found) n_hit++;
                    else            n_miss++;
                end
                else
                begin
                    case (want.status)
                        siht_pkg::ST_OK:      n_placed++;
                        siht_pkg::ST_EXISTS:  n_exists++;
                        siht_pkg::ST_INVALID: n_invalid++;
                        default:              n_full++;
                    endcase
                end
            end
            if (!hold)
            begin
                if (request_words.size() != 0 && $urandom_range(99) >= req_idle_pct)
                begin
                    nxt = request_words.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.command    <= nxt.command;
                    req_ch.irq_number <= nxt.irq_number;
                    req_ch.owner_task <= nxt.owner_task;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Response monitor: checks each taken word against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : response_monitor
        reply_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, got status %0d task 0x%0h",
                             $time, rsp_ch.status, rsp_ch.found_task);
                    mismatches++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp_ch.status));
                    check_field("found", 32'(want.found), 32'(rsp_ch.found));
                    check_field("found_task", want.found_task, rsp_ch.found_task);
                    check_field("enable_request", 32'(want.enable_request),
                                32'(rsp_ch.enable_request));
                    check_field("enable_number", 32'(want.enable_number),
                                32'(rsp_ch.enable_number));
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    task automatic queue_word(logic cmd, int irq, logic [siht_pkg::TASK_W-1:0] owner);
        request_t w;
        w.command    = cmd;
        w.irq_number = irq[siht_pkg::KEY_W-1:0];
        w.owner_task = owner;
        request_words = {request_words, w};
        words_queued++;
    endtask

    // Mostly random owners, with the all-zero and all-one extremes now and then.
    function automatic logic [siht_pkg::TASK_W-1:0] random_owner();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Block is idle once every queued word went in and every response came out.
    task automatic wait_until_drained();
        @(posedge clk);
        while (words_accepted != words_queued || expected_replies.size() != 0)
            @(posedge clk);
    endtask

    // One phase: write the limit while idle, set the idling mix, send a batch
    // of random words and wait for all responses.
    task automatic run_phase(int limit, int idle_pct, int stall_pct, int n_words, int new_pct);
        int r;
        int key;
        int top_key;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= limit[siht_pkg::LIMIT_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        irq_limit  = limit[siht_pkg::LIMIT_W-1:0];
        req_idle_pct  = idle_pct;
        rsp_stall_pct = stall_pct;
        top_key = (limit > 1024) ? 1023 : limit - 1;
        for (int n = 0; n < n_words; n++)
        begin
            r = $urandom_range(99);
            if (r < new_pct || key_pool.size() == 0)
            begin
                // fresh key, usually inside the current limit
                if (top_key >= 0 && $urandom_range(99) < 85)
                    key = $urandom_range(top_key, 0);
                else
                    key = $urandom_range(1023, 0);
                key_pool = {key_pool, key};
                queue_word(siht_pkg::CMD_INSERT, key, random_owner());
            end
            else if (r < new_pct + 10)
                queue_word(siht_pkg::CMD_INSERT,
                           key_pool[$urandom_range(key_pool.size() - 1)], random_owner());
            else if (r < new_pct + 15)
                queue_word(siht_pkg::CMD_INSERT, $urandom_range(1023, 0), random_owner());
            else if ($urandom_range(99) < 60)
                queue_word(siht_pkg::CMD_LOOKUP,
                           key_pool[$urandom_range(key_pool.size() - 1)], random_owner());
            else
                queue_word(siht_pkg::CMD_LOOKUP, $urandom_range(1023, 0), random_owner());
        end
        wait_until_drained();
    endtask

    initial
    begin
        // X -> 0 on rst_n resets the driver and monitor at time zero
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset limit, no idling: empty-table lookup,
        // inserts at both key extremes and in the middle, a duplicate, and
        // lookups that hit and miss around the stored keys.
        queue_word(siht_pkg::CMD_LOOKUP, 0, '1);
        queue_word(siht_pkg::CMD_INSERT, 512, 32'hA5A5_A5A5);
        queue_word(siht_pkg::CMD_INSERT, 0, '0);
        queue_word(siht_pkg::CMD_INSERT, 1023, '1);
        queue_word(siht_pkg::CMD_INSERT, 511, 32'h1234_5678);
        queue_word(siht_pkg::CMD_INSERT, 1, 32'h5A5A_5A5A);
        queue_word(siht_pkg::CMD_INSERT, 512, '0);
        queue_word(siht_pkg::CMD_LOOKUP, 0, '0);
        queue_word(siht_pkg::CMD_LOOKUP, 1023, '0);
        queue_word(siht_pkg::CMD_LOOKUP, 512, '0);
        queue_word(siht_pkg::CMD_LOOKUP, 511, '0);
        queue_word(siht_pkg::CMD_LOOKUP, 513, '0);
        queue_word(siht_pkg::CMD_LOOKUP, 1022, '0);
        key_pool = '{512, 0, 1023, 511, 1};
        wait_until_drained();

        // Random phases over a range of limits (zero, one, mid values, the
        // reset value, just above it and the 11-bit maximum) and all idling
        // mixes. Inserts are kept sparse so the table fills gradually; the
        // later phases then run against a full table.
        run_phase(0,    45,  0, 120, 20);
        run_phase(1,     0, 45, 100, 20);
        run_phase(300,  33, 33, 250, 12);
        run_phase(2047,  0,  0, 250, 10);
        run_phase(1024, 45,  0, 300, 10);
        run_phase(1025,  0, 45, 250, 10);
        run_phase(517,  33, 33, 250, 10);
        run_phase(5,     0,  0, 230, 10);

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d words: inserts %0d placed, %0d duplicate, %0d out of range, %0d full;",
                 words_accepted, n_placed, n_exists, n_invalid, n_full);
        $display("lookups %0d hit, %0d missed; table ended with %0d of %0d entries.",
                 n_hit, n_miss, tbl_count, siht_pkg::TABLE_DEPTH);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
